// File: design/bsts_pkg.sv
// Shared types and constants of the blob shadow texture stamper.
// Holds the command and state encodings and the blob shape tables; depends on nothing.
`timescale 1ns / 1ps

package bsts_pkg;

  localparam int ADDR_W    = 12;
  localparam int COORD_W   = 10;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;
  localparam int SHAPE_W   = 3;

  localparam logic [PIX_W-1:0] PIX_FULL   = 8'd255;
  localparam logic [PIX_W-1:0] SHADE_BASE = 8'd254;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STAMP = 2'd1,
    CMD_SHADE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  localparam logic [CFG_IDX_W-1:0] REG_BORDER      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_SLOPE = 2'd2;

  localparam int SHAPE_COUNT = 5;
  localparam int MAX_ROWS    = 14;
  localparam logic [SHAPE_W-1:0] SHAPE_TINY = 3'd3;

  localparam logic [3:0] SHAPE_ROWS [SHAPE_COUNT] = '{4'd7, 4'd8, 4'd12, 4'd6, 4'd14};
  localparam logic [3:0] SHAPE_TOP  [SHAPE_COUNT] = '{4'd3, 4'd4, 4'd6, 4'd2, 4'd7};
  localparam logic       SHAPE_TRIM [SHAPE_COUNT] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  localparam logic [3:0] SHAPE_HALF [SHAPE_COUNT][MAX_ROWS] = '{
    '{4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd4, 4'd2, 4'd0, 4'd0},
    '{4'd1, 4'd2, 4'd3, 4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd2}
  };

endpackage

// File: design/blob_shadow_texture_stamper.sv
// Blob shadow texture stamper, top level; uses bsts_pkg.
// The texture sits in one synchronous memory, one texture row per word.
//
// One request enters on in_valid/in_stall and gives exactly one result on
// out_valid/out_stall. The block takes one request at a time; in_stall is
// high from acceptance until the result has been loaded into the output
// register, which may still be waiting for the receiver when the next
// request is taken. Each request steps through rows of the single row-wide
// memory, which is read and written once per cycle:
//   clear, shade: all TEX_SIDE rows (no rows when shading is disabled),
//   stamp: the blob rows (6 to 14 rows), read: one row.
// A stalled receiver holds the finished result and the block waits in its
// final state. Configuration writes on cfg_valid/cfg_ready are always taken
// and must come while no request is in flight. Reset clears the registers
// and one valid bit per texture row, so the texture reads as all zero
// immediately after reset. TEX_SIDE must be a power of two.
`timescale 1ns / 1ps

module blob_shadow_texture_stamper
  import bsts_pkg::*;
#(
  parameter int TEX_SIDE = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 command,
  input  logic signed [COORD_W-1:0]  center_col,
  input  logic signed [COORD_W-1:0]  center_row,
  input  logic [SHAPE_W-1:0]         blob_shape,
  input  logic [ADDR_W-1:0]          read_address,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [PIX_W-1:0]           pixel_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int SB    = $clog2(TEX_SIDE);
  localparam int ROW_W = TEX_SIDE * PIX_W;
  localparam int CW    = 12;

  state_t state, state_next;

  logic             border_pattern;
  logic             shade_enable;
  logic [PIX_W-1:0] shade_slope;

  cmd_t                      op;
  logic signed [COORD_W-1:0] ccol;
  logic signed [COORD_W-1:0] crow;
  logic [SHAPE_W-1:0]        shape;
  logic [ADDR_W-1:0]         addr;
  logic [SB-1:0]             cnt;
  logic [SB-1:0]             last_idx;
  logic [PIX_W-1:0]          shade_val;

  logic [ROW_W-1:0]    mem [TEX_SIDE];
  logic [TEX_SIDE-1:0] row_valid;
  logic [ROW_W-1:0]    rd_q;

  logic                 s1_valid;
  cmd_t                 s1_op;
  logic [SB-1:0]        s1_row;
  logic signed [CW-1:0] s1_lo;
  logic signed [CW-1:0] s1_hi;
  logic [PIX_W-1:0]     s1_val;
  logic                 s1_rv;

  logic                 accept;
  logic                 out_load;
  logic                 issue;
  logic                 rd_en;
  logic                 wr_en;
  logic [SB-1:0]        iss_row;
  logic [3:0]           k;
  logic [3:0]           half;
  logic signed [CW-1:0] row_s;
  logic signed [CW-1:0] lo;
  logic signed [CW-1:0] hi;
  logic                 row_ok;
  logic                 addr_ok;
  logic [SB-1:0]        addr_row;
  logic [SB-1:0]        addr_col;
  logic [ROW_W-1:0]     wr_data;
  logic [PIX_W-1:0]     result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_pattern <= 1'b0;
      shade_enable   <= 1'b0;
      shade_slope    <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BORDER:      border_pattern <= cfg_data[0];
        REG_SHADE_EN:    shade_enable   <= cfg_data[0];
        REG_SHADE_SLOPE: shade_slope    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (cmd_t'(command) == CMD_SHADE && !shade_enable) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (cnt == last_idx) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (state == ST_RUN) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= cmd_t'(command);
      ccol      <= center_col;
      crow      <= center_row;
      shape     <= (blob_shape < SHAPE_W'(SHAPE_COUNT)) ? blob_shape : SHAPE_TINY;
      addr      <= read_address;
      shade_val <= SHADE_BASE;
    end else if (issue && op == CMD_SHADE) begin
      shade_val <= shade_val - shade_slope;
    end
  end

  always_comb begin
    unique case (op)
      CMD_CLEAR, CMD_SHADE: last_idx = SB'(TEX_SIDE - 1);
      CMD_STAMP:            last_idx = SB'(SHAPE_ROWS[shape] - 4'd1);
      CMD_READ:             last_idx = '0;
      default:              last_idx = '0;
    endcase
  end

  assign k     = cnt[3:0];
  assign half  = SHAPE_HALF[shape][k];
  assign row_s = $signed({{(CW-COORD_W){crow[COORD_W-1]}}, crow})
               - $signed({{(CW-4){1'b0}}, SHAPE_TOP[shape]})
               + $signed({{(CW-4){1'b0}}, k});
  assign lo    = $signed({{(CW-COORD_W){ccol[COORD_W-1]}}, ccol})
               - $signed({{(CW-4){1'b0}}, half});
  assign hi    = $signed({{(CW-COORD_W){ccol[COORD_W-1]}}, ccol})
               + $signed({{(CW-4){1'b0}}, half})
               - $signed(CW'(1))
               - $signed({{(CW-1){1'b0}}, SHAPE_TRIM[shape]});
  assign row_ok = !row_s[CW-1] && (row_s < $signed(CW'(TEX_SIDE)));

  assign addr_ok  = (32'(addr) >> (2 * SB)) == 32'd0;
  assign addr_row = SB'(32'(addr) >> SB);
  assign addr_col = SB'(addr);

  always_comb begin
    unique case (op)
      CMD_CLEAR, CMD_SHADE: iss_row = cnt;
      CMD_STAMP:            iss_row = row_s[SB-1:0];
      CMD_READ:             iss_row = addr_row;
      default:              iss_row = cnt;
    endcase
  end

  assign issue = (state == ST_RUN) && (op != CMD_STAMP || row_ok);
  assign rd_en = issue && op != CMD_CLEAR;
  assign wr_en = s1_valid && s1_op != CMD_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_op  <= op;
      s1_row <= iss_row;
      s1_lo  <= lo;
      s1_hi  <= hi;
      s1_val <= shade_val;
      s1_rv  <= row_valid[iss_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[iss_row];
    end
    if (wr_en) begin
      mem[s1_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[s1_row] <= 1'b1;
    end
  end

  always_comb begin
    logic [PIX_W-1:0]     cur;
    logic signed [CW-1:0] col_s;
    logic                 edge_px;
    for (int c = 0; c < TEX_SIDE; c++) begin
      cur     = s1_rv ? rd_q[c*PIX_W +: PIX_W] : '0;
      col_s   = $signed(CW'(c));
      edge_px = (s1_row == '0) || (s1_row == SB'(TEX_SIDE - 1))
             || (c == 0) || (c == TEX_SIDE - 1);
      unique case (s1_op)
        CMD_CLEAR: wr_data[c*PIX_W +: PIX_W] = (border_pattern && edge_px) ? PIX_FULL : '0;
        CMD_STAMP: wr_data[c*PIX_W +: PIX_W] =
                     (col_s >= s1_lo && col_s <= s1_hi) ? PIX_FULL : cur;
        CMD_SHADE: wr_data[c*PIX_W +: PIX_W] = (cur != '0) ? s1_val : '0;
        CMD_READ:  wr_data[c*PIX_W +: PIX_W] = cur;
        default:   wr_data[c*PIX_W +: PIX_W] = cur;
      endcase
    end
  end

  assign result = (op == CMD_READ && addr_ok && s1_rv) ? rd_q[addr_col*PIX_W +: PIX_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_value <= result;
    end
  end

`ifndef SYNTHESIS
  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result appeared outside the final state");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !wr_en)
    else $error("texture written while no request is in flight");

  a_no_row_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> iss_row != s1_row)
    else $error("row read while its write-back is pending");

  a_one_issue_per_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s1_valid)
    else $error("write-back stage busy at the start of a request");
`endif

endmodule
